### rtl/mowt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mowt_pkg;
  localparam int unsigned MaxStates  = 1024;
  localparam int unsigned MaxPairs   = 16384;
  localparam int unsigned SymbolBits = 16;
  localparam int unsigned StBits  = $clog2(MaxStates);
  localparam int unsigned PaBits  = $clog2(MaxPairs);
  localparam int unsigned PtrBits = PaBits + 1;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_FINISH = 3'd1,
    OP_LK_SYM = 3'd2,
    OP_LK_WT  = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RANGE    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  state_id;
    logic [15:0] symbol;
    logic [30:0] weight;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_symbol;
    logic [30:0] found_weight;
  } rsp_t;

  // one state table entry: valid flag, start and count of a committed group
  typedef struct packed {
    logic               vld;
    logic [PaBits-1:0]  start;
    logic [PtrBits-1:0] count;
  } tab_t;

  typedef struct packed {
    logic [SymbolBits-1:0] sym;
    logic [30:0]           wt;
  } pair_t;
endpackage
`default_nettype wire

### rtl/mowt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mowt_req_if;
  logic            valid;
  logic            ready;
  mowt_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mowt_rsp_if;
  logic            valid;
  logic            ready;
  mowt_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/mowt_tab_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module mowt_tab_mem (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clr_i,
  input  wire logic                        we_i,
  input  wire logic [mowt_pkg::StBits-1:0] waddr_i,
  input  wire mowt_pkg::tab_t              wdata_i,
  input  wire logic [mowt_pkg::StBits-1:0] raddr_i,
  output mowt_pkg::tab_t                   rdata_o,
  output logic                             busy_o
);
  import mowt_pkg::*;
  tab_t mem_q [MaxStates];

  // clearing pass: one entry per cycle after reset and after a clear
  logic              clr_q;
  logic [StBits-1:0] clr_cnt_q;
  logic              mem_we;
  logic [StBits-1:0] mem_waddr;
  tab_t              mem_wdata;

  assign busy_o    = clr_q;
  assign mem_we    = clr_q || we_i;
  assign mem_waddr = clr_q ? clr_cnt_q : waddr_i;
  assign mem_wdata = clr_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_o <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_i) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == StBits'(MaxStates - 1)) clr_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/mowt_pair_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module mowt_pair_mem (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [mowt_pkg::PaBits-1:0] waddr_i,
  input  wire mowt_pkg::pair_t             wdata_i,
  input  wire logic [mowt_pkg::PaBits-1:0] raddr_i,
  output mowt_pkg::pair_t                  rdata_o
);
  import mowt_pkg::*;
  pair_t mem_q [MaxPairs];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/mealy_output_weight_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// load, finish, clear and unused opcodes pass from S_TAB straight to S_OUT after acceptance;
// a lookup passes through S_TAB, then S_RD and S_CMP for each binary search step, and
// also S_FRD and S_FIN when a weight search ends on a remembered pair, then S_OUT;
// each read step takes its own state because the pair memory read is registered
// one transaction at a time; the next item is taken only once the result has left and S_IDLE is reached
// reset and clear run a clearing pass over all 1024 state table entries, input held off
module mealy_output_weight_table_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mowt_req_if.sink   req,
  mowt_rsp_if.source rsp
);
  import mowt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TAB  = 3'd1; // state table read in flight
  localparam logic [2:0] S_RD   = 3'd2; // pair read issued
  localparam logic [2:0] S_CMP  = 3'd3; // pair data back
  localparam logic [2:0] S_FRD  = 3'd4; // final pair read issued
  localparam logic [2:0] S_FIN  = 3'd5; // final pair data back
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic signed [PtrBits:0] IdxOne = (PtrBits + 1)'(1);

  logic [2:0] state_q;
  req_t r_q;
  rsp_t out_q;

  // open group
  logic [PtrBits-1:0] wp_q, pcnt_q;
  logic [StBits-1:0]  pst_q;
  logic               pvld_q;
  logic [PaBits-1:0]  pstart_q;

  // search registers, signed with one spare bit so hi may drop to -1
  logic signed [PtrBits:0] lo_q, hi_q, best_q;
  logic [PaBits-1:0] start_q;
  logic [PaBits-1:0] mid_addr_q;
  logic signed [PtrBits:0] mid;

  // memory ports
  logic tab_we, tab_clr;
  logic [StBits-1:0] tab_waddr;
  tab_t tab_wdata, tab_rdata;
  logic tab_busy;
  logic pair_we;
  logic [PaBits-1:0] pair_raddr;
  pair_t pair_rdata;

  wire accept = req.valid && req.ready;
  wire opcode_e op = opcode_e'(r_q.opcode);
  wire [PtrBits:0] sum = PtrBits'(0) + (lo_q + hi_q);

  // input held off while the state table is being cleared
  assign req.ready = (state_q == S_IDLE) && !tab_busy;
  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data  = out_q;
  assign mid = $signed({sum[PtrBits], sum[PtrBits:1]});

  mowt_tab_mem u_tab (
    .clk_i, .rst_ni,
    .clr_i(tab_clr), .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(tab_wdata),
    .raddr_i(req.data.state_id[StBits-1:0]), .rdata_o(tab_rdata), .busy_o(tab_busy)
  );

  mowt_pair_mem u_pair (
    .clk_i, .we_i(pair_we), .waddr_i(wp_q[PaBits-1:0]),
    .wdata_i({r_q.symbol[SymbolBits-1:0], r_q.weight}),
    .raddr_i(pair_raddr), .rdata_o(pair_rdata)
  );

  wire st_range = 32'(r_q.state_id) >= MaxStates;
  wire load_ok = (op == OP_LOAD) && (state_q == S_TAB) && !st_range &&
                 (wp_q < PtrBits'(MaxPairs));
  wire new_grp = !pvld_q || (r_q.state_id[StBits-1:0] != pst_q);
  wire do_commit = (state_q == S_TAB) &&
                   ((load_ok && new_grp) || (op == OP_FINISH)) && pvld_q;
  assign tab_we    = do_commit;
  assign tab_waddr = pst_q;
  assign tab_wdata = '{vld: 1'b1, start: pstart_q, count: pcnt_q};
  assign tab_clr   = (state_q == S_TAB) && (op == OP_CLEAR);
  assign pair_we   = load_ok;
  assign pair_raddr = mid_addr_q;

  // compare of returned pair against key
  wire sym_eq = pair_rdata.sym == r_q.symbol[SymbolBits-1:0];
  wire sym_lt = pair_rdata.sym <  r_q.symbol[SymbolBits-1:0];
  wire wt_le  = pair_rdata.wt  <= r_q.weight;

  always_ff @(posedge clk_i) begin
    if (accept) r_q <= req.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q <= '0; pcnt_q <= '0; pst_q <= '0; pvld_q <= 1'b0; pstart_q <= '0;
      lo_q <= '0; hi_q <= '0; best_q <= '0; start_q <= '0; mid_addr_q <= '0;
      out_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (accept) state_q <= S_TAB;
        S_TAB: begin
          status_e stat;
          logic    srch;
          stat = ST_OK;
          srch = 1'b0;
          priority if (op == OP_LOAD) begin
            if (st_range) stat = ST_RANGE;
            else if (!load_ok) stat = ST_FULL;
            else begin
              if (new_grp) begin
                pst_q <= r_q.state_id[StBits-1:0];
                pvld_q <= 1'b1;
                pstart_q <= wp_q[PaBits-1:0];
                pcnt_q <= PtrBits'(1);
              end else pcnt_q <= pcnt_q + 1'b1;
              wp_q <= wp_q + 1'b1;
            end
          end else if (op == OP_FINISH) begin
            pvld_q <= 1'b0; pst_q <= '0; pstart_q <= '0; pcnt_q <= '0;
          end else if (op == OP_CLEAR) begin
            pvld_q <= 1'b0; pst_q <= '0; pstart_q <= '0; pcnt_q <= '0; wp_q <= '0;
          end else if (op == OP_LK_SYM || op == OP_LK_WT) begin
            if (st_range) stat = ST_RANGE;
            else if (!tab_rdata.vld) stat = ST_NOTFOUND;
            else begin
              // first probe: lo = 0, hi = count - 1
              lo_q <= '0;
              hi_q <= $signed({1'b0, tab_rdata.count} - (PtrBits + 1)'(1));
              best_q <= '1;
              start_q <= tab_rdata.start;
              mid_addr_q <= tab_rdata.start +
                            PaBits'((tab_rdata.count - 1'b1) >> 1);
              srch = 1'b1;
            end
          end else begin
            // unused opcodes: no effect
          end
          out_q <= '{status: stat, found_symbol: '0, found_weight: '0};
          state_q <= srch ? S_RD : S_OUT;
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (op == OP_LK_SYM) begin
            if (sym_eq) begin
              out_q <= '{status: ST_OK, found_symbol: pair_rdata.sym,
                         found_weight: pair_rdata.wt};
              state_q <= S_OUT;
            end else begin
              logic signed [PtrBits:0] nlo, nhi, nsum;
              nlo = sym_lt ? mid + IdxOne : lo_q;
              nhi = sym_lt ? hi_q : mid - IdxOne;
              nsum = nlo + nhi;
              lo_q <= nlo; hi_q <= nhi;
              if (nlo > nhi) begin
                out_q.status <= ST_NOTFOUND;
                state_q <= S_OUT;
              end else begin
                mid_addr_q <= start_q + PaBits'(nsum >>> 1);
                state_q <= S_RD;
              end
            end
          end else begin
            logic signed [PtrBits:0] nlo, nhi, nsum, nbest;
            nlo = wt_le ? mid + IdxOne : lo_q;
            nhi = wt_le ? hi_q : mid - IdxOne;
            nbest = wt_le ? mid : best_q;
            nsum = nlo + nhi;
            lo_q <= nlo; hi_q <= nhi; best_q <= nbest;
            if (nlo > nhi) begin
              if (nbest < 0) begin
                out_q.status <= ST_NOTFOUND;
                state_q <= S_OUT;
              end else begin
                mid_addr_q <= start_q + PaBits'(nbest);
                state_q <= S_FRD;
              end
            end else begin
              mid_addr_q <= start_q + PaBits'(nsum >>> 1);
              state_q <= S_RD;
            end
          end
        end
        S_FRD: state_q <= S_FIN;
        S_FIN: begin
          out_q <= '{status: ST_OK, found_symbol: pair_rdata.sym,
                     found_weight: pair_rdata.wt};
          state_q <= S_OUT;
        end
        S_OUT: if (rsp.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mowt_pkg::*;

  localparam int ReqBits = $bits(req_t);

  logic clk_i;
  logic rst_ni;

  mowt_req_if req_ch ();
  mowt_rsp_if rsp_ch ();

  mealy_output_weight_table_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  // shadow copy of the weight table, kept in step with accepted requests
  logic              tbl_valid [MaxStates];
  logic [31:0]       tbl_start [MaxStates];
  logic [31:0]       tbl_count [MaxStates];
  logic [15:0]       mem_sym [MaxPairs];
  logic [30:0]       mem_wt [MaxPairs];
  int unsigned       wr_ptr;
  int unsigned       grp_state;
  logic              grp_open;
  int unsigned       grp_start;
  int unsigned       grp_count;

  req_t req_queue[$];     // requests waiting to be driven
  rsp_t answer_queue[$];  // predicted responses, oldest first
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   send_hold;        // pause sender while set
  logic req_acc_q;        // offered transaction taken at the last rising edge
  int   errors;
  longint cycles;

  // commit the open group into the table
  function automatic void close_group();
    if (grp_open) begin
      tbl_valid[grp_state] = 1'b1;
      tbl_start[grp_state] = grp_start;
      tbl_count[grp_state] = grp_count;
    end
    grp_open = 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < MaxStates; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_start[i] = 0;
      tbl_count[i] = 0;
    end
    wr_ptr    = 0;
    grp_state = 0;
    grp_open  = 1'b0;
    grp_start = 0;
    grp_count = 0;
  endfunction

  // work out the answer to one accepted request and update the shadow table
  function automatic rsp_t predict_answer(req_t r);
    rsp_t a;
    int lo, hi, mid, best;
    int unsigned base, n;
    a = '0;
    case (r.opcode)
      OP_LOAD: begin
        if (wr_ptr >= MaxPairs) begin
          a.status = ST_FULL;
        end else begin
          if (!grp_open || r.state_id != grp_state) begin
            close_group();
            grp_state = r.state_id;
            grp_open  = 1'b1;
            grp_start = wr_ptr;
            grp_count = 0;
          end
          mem_sym[wr_ptr] = r.symbol;
          mem_wt[wr_ptr]  = r.weight;
          wr_ptr++;
          grp_count++;
          a.status = ST_OK;
        end
      end
      OP_FINISH: begin
        close_group();
        grp_state = 0;
        grp_start = 0;
        grp_count = 0;
      end
      OP_LK_SYM, OP_LK_WT: begin
        if (!tbl_valid[r.state_id]) begin
          a.status = ST_NOTFOUND;
        end else begin
          base = tbl_start[r.state_id];
          n    = tbl_count[r.state_id];
          lo = 0;
          hi = int'(n) - 1;
          best = -1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (r.opcode == OP_LK_SYM) begin
              if (mem_sym[base + mid] == r.symbol) begin
                best = mid;
                break;
              end
              if (mem_sym[base + mid] < r.symbol) lo = mid + 1;
              else hi = mid - 1;
            end else begin
              if (mem_wt[base + mid] <= r.weight) begin
                best = mid;
                lo = mid + 1;
              end else begin
                hi = mid - 1;
              end
            end
          end
          if (best < 0) begin
            a.status = ST_NOTFOUND;
          end else begin
            a.status       = ST_OK;
            a.found_symbol = mem_sym[base + best];
            a.found_weight = mem_wt[base + best];
          end
        end
      end
      OP_CLEAR: wipe_table();
      default: ;
    endcase
    return a;
  endfunction

  function automatic req_t mk_req(opcode_e op, int unsigned st, logic [15:0] sym,
                                  logic [30:0] wt);
    req_t r;
    r.opcode   = op;
    r.state_id = st[9:0];
    r.symbol   = sym;
    r.weight   = wt;
    return r;
  endfunction

  function automatic logic [30:0] rand_wt();
    return {$urandom} & 31'h7fffffff;
  endfunction

  // append one request to the pending queue
  function automatic void add_req(req_t r);
    req_queue.insert(req_queue.size(), r);
  endfunction

  // one group: symbols and weights rising by random steps (they may wrap in long groups), then probes
  task automatic push_group(int unsigned st, int unsigned n);
    logic [15:0] s;
    logic [30:0] w;
    logic [15:0] syms[$];
    logic [30:0] wts[$];
    s = $urandom_range(0, 300);
    w = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      add_req(mk_req(OP_LOAD, st, s, w));
      syms.insert(syms.size(), s);
      wts.insert(wts.size(), w);
      s = s + $urandom_range(1, 4000);
      w = w + ($urandom_range(1, 1 << 24) << $urandom_range(0, 6));
    end
    if ($urandom_range(0, 1)) add_req(mk_req(OP_FINISH, 0, 0, 0));
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 1))
        add_req(mk_req(OP_LK_SYM, st,
          ($urandom_range(0, 2) != 0) ? syms[$urandom_range(0, n - 1)] : $urandom, 0));
      else
        add_req(mk_req(OP_LK_WT, st, $urandom,
          wts[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1));
    end
  endtask

  // noise: any opcode, any field bits, unsorted loads
  task automatic push_noise();
    req_t r;
    r = ReqBits'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) r.state_id = $urandom_range(0, 15);
    add_req(r);
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || answer_queue.size() != 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    req_acc_q <= req_ch.valid && req_ch.ready;
  end

  // driver: changes on the falling edge, offers the head of the queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_acc_q) begin
      // hold the offered transaction
    end else if (req_queue.size() != 0 && !send_hold &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      req_ch.valid <= 1'b1;
      req_ch.data  <= req_queue.pop_front();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    rsp_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: predict on request acceptance, check on response acceptance
  always @(posedge clk_i) begin
    rsp_t exp_a;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        answer_queue.insert(answer_queue.size(), predict_answer(req_ch.data));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answer_queue.size() == 0) begin
          $display("%0t unexpected transaction %h", $time, rsp_ch.data);
          errors++;
        end else begin
          exp_a = answer_queue.pop_front();
          if (rsp_ch.data !== exp_a) begin
            $display("%0t mismatch expected st=%0d sym=%h wt=%h actual st=%0d sym=%h wt=%h",
                     $time, exp_a.status, exp_a.found_symbol, exp_a.found_weight,
                     rsp_ch.data.status, rsp_ch.data.found_symbol, rsp_ch.data.found_weight);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned st;
    req_ch.valid  = 1'b0;
    req_ch.data   = '0;
    rsp_ch.ready  = 1'b0;
    send_hold     = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 77;
    errors        = 0;
    wipe_table();
    for (int i = 0; i < MaxPairs; i++) begin
      mem_sym[i] = '0;
      mem_wt[i]  = '0;
    end
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty lookups, extremes, finish with no group, unused opcodes
    add_req(mk_req(OP_LK_SYM, 0, 0, 0));
    add_req(mk_req(OP_LK_WT, 1023, 16'hffff, 31'h7fffffff));
    add_req(mk_req(OP_FINISH, 0, 0, 0));
    add_req(mk_req(OP_LOAD, 1023, 16'h0000, 31'h0));
    add_req(mk_req(OP_LOAD, 1023, 16'hffff, 31'h7fffffff));
    add_req(mk_req(OP_LK_SYM, 1023, 16'hffff, 0)); // still pending
    add_req(mk_req(OP_LOAD, 0, 16'h0005, 31'd10));  // commits 1023
    add_req(mk_req(OP_FINISH, 0, 0, 0));
    add_req(mk_req(OP_LK_SYM, 1023, 16'hffff, 0));
    add_req(mk_req(OP_LK_SYM, 1023, 16'h1234, 0));
    add_req(mk_req(OP_LK_WT, 1023, 0, 31'h7ffffffe));
    add_req(mk_req(OP_LK_WT, 0, 0, 31'd9));          // below every weight
    add_req(mk_req(OP_LK_WT, 0, 0, 31'd10));
    add_req(mk_req(OP_LOAD, 0, 16'h0009, 31'd1));   // replacement group
    add_req(mk_req(OP_FINISH, 0, 0, 0));
    add_req(mk_req(OP_LK_SYM, 0, 16'h0005, 0));
    add_req(mk_req(opcode_e'(3'd5), 7, 16'h1, 31'h1));
    add_req(mk_req(opcode_e'(3'd6), 7, 16'h1, 31'h1));
    add_req(mk_req(opcode_e'(3'd7), 7, 16'h1, 31'h1));
    add_req(mk_req(OP_CLEAR, 0, 0, 0));
    add_req(mk_req(OP_LK_SYM, 0, 16'h0009, 0));
    // sender waits for every answer before going on
    wait_drained();
    send_hold = 1'b1;
    repeat (20) @(posedge clk_i);
    send_hold = 1'b0;

    // random phases with different idling
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 77;
        recv_idle_pct = 15;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int g = 0; g < 19; g++) begin
        st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        push_group(st, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6));
        if ($urandom_range(0, 2) == 0) push_noise();
        if ($urandom_range(0, 40) == 0) add_req(mk_req(OP_CLEAR, 0, 0, 0));
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
